/* rtl/ira_pkg.sv */
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types and constants of the interrupt line range allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

    localparam int NUM_LINES_DEF = 1024;
    localparam int MAX_RUN_DEF   = 32;

    // fixed field widths
    localparam int LINE_FW  = 10;
    localparam int COUNT_FW = 6;
    localparam int CFG_DW   = 11;
    localparam int CFG_IW   = 2;
    // run counter, wide enough for MAX_RUN up to 64
    localparam int RUN_W    = 7;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_MSI_BASE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MSI_COUNT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TOP_INDEX = 2'd2;

    localparam logic [9:0]  MSI_BASE_RST  = 10'd32;
    localparam logic [10:0] MSI_COUNT_RST = 11'd0;
    localparam logic [9:0]  TOP_INDEX_RST = 10'd1023;

    typedef enum logic [1:0] {
        CMD_RESERVE   = 2'd0,
        CMD_INSTALL   = 2'd1,
        CMD_UNINSTALL = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [LINE_FW-1:0]  line;
        logic [COUNT_FW-1:0] count;
        logic                aligned;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic [LINE_FW-1:0] first_line;
    } out_item_t;

    typedef enum logic [1:0] {
        WR_CLEAR = 2'd0,
        WR_LINE  = 2'd1,
        WR_MARK  = 2'd2
    } wr_src_t;

    typedef enum logic [1:0] {
        RES_FAIL    = 2'd0,
        RES_OK_ZERO = 2'd1,
        RES_OK_RUN  = 2'd2
    } res_code_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_OUTER,
        ST_EVAL_I,
        ST_INNER,
        ST_EVAL_J,
        ST_STOP,
        ST_MARK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic      load;
        logic      clr_step;
        logic      scan_init;
        logic      i_inc;
        logic      i_adv;
        logic      j_clear;
        logic      j_inc;
        logic      rd_en;
        logic      wr_en;
        wr_src_t   wr_src;
        logic      pend_set;
        res_code_t pend_code;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] cmd;
        logic       too_big;
        logic       line_ok;
        logic       outer_ok;
        logic       inner_ok;
        logic       bit_taken;
        logic       count_zero;
        logic       run_done;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/ira_ram.sv */
// ----------------------------------------------------------------------------
// ira_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/ira_ctrl.sv */
// ----------------------------------------------------------------------------
// ira_ctrl
// Sequencer for clearing, dispatch, range scan, run marking and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ctrl
    import ira_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_src   = WR_CLEAR;
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.pend_set  = 1'b1;
                cmd.pend_code = RES_FAIL;
                state_next    = ST_DONE;
                case (status.cmd)
                    CMD_RESERVE: begin
                        if (!status.too_big) begin
                            cmd.pend_set  = 1'b0;
                            cmd.scan_init = 1'b1;
                            state_next    = ST_OUTER;
                        end
                    end
                    CMD_INSTALL, CMD_UNINSTALL: begin
                        if (status.line_ok) begin
                            cmd.wr_en     = 1'b1;
                            cmd.wr_src    = WR_LINE;
                            cmd.pend_code = RES_OK_ZERO;
                        end
                    end
                    default: begin
                        cmd.pend_code = RES_FAIL;
                    end
                endcase
            end
            ST_OUTER: begin
                // j is zero here, so the read address is the start line
                if (status.outer_ok) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_EVAL_I;
                end else begin
                    cmd.pend_set  = 1'b1;
                    cmd.pend_code = RES_FAIL;
                    state_next    = ST_DONE;
                end
            end
            ST_EVAL_I: begin
                if (status.bit_taken) begin
                    cmd.i_inc   = 1'b1;
                    cmd.j_clear = 1'b1;
                    state_next  = ST_OUTER;
                end else if (status.count_zero) begin
                    cmd.pend_set  = 1'b1;
                    cmd.pend_code = RES_OK_RUN;
                    state_next    = ST_DONE;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_INNER;
                end
            end
            ST_INNER: begin
                if (status.inner_ok) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_EVAL_J;
                end else begin
                    state_next = ST_STOP;
                end
            end
            ST_EVAL_J: begin
                if (status.bit_taken) begin
                    state_next = ST_STOP;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_INNER;
                end
            end
            ST_STOP: begin
                cmd.j_clear = 1'b1;
                if (status.run_done) begin
                    state_next = ST_MARK;
                end else begin
                    cmd.i_adv  = 1'b1;
                    state_next = ST_OUTER;
                end
            end
            ST_MARK: begin
                if (status.run_done) begin
                    cmd.pend_set  = 1'b1;
                    cmd.pend_code = RES_OK_RUN;
                    state_next    = ST_DONE;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = WR_MARK;
                    cmd.j_inc  = 1'b1;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/ira_dp.sv */
// ----------------------------------------------------------------------------
// ira_dp
// Datapath: configuration, scan pointers, taken map RAM and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_dp
    import ira_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_wdata,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status
);

    localparam int LINE_W = $clog2(NUM_LINES);
    // holds the window end and a start line pushed past the limit by a run
    localparam int SCAN_W = ((LINE_W > LINE_FW) ? LINE_W : LINE_FW) + 2;

    logic [9:0]  msi_base_reg;
    logic [10:0] msi_count_reg;
    logic [9:0]  top_index_reg;

    in_item_t           in_reg;
    logic [SCAN_W-1:0]  i_reg;
    logic [RUN_W-1:0]   j_reg;
    logic [LINE_W-1:0]  clr_reg;
    logic               pend_ok_reg;
    logic [LINE_FW-1:0] pend_first_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [SCAN_W-1:0] lim;
    logic [SCAN_W-1:0] top_ext;
    logic [SCAN_W-1:0] win_end;
    logic [SCAN_W-1:0] pos;
    logic [SCAN_W-1:0] line_ext;
    logic [RUN_W-1:0]  count_ext;
    logic [SCAN_W-1:0] step;

    logic              ram_we;
    logic [LINE_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic              ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msi_base_reg  <= MSI_BASE_RST;
            msi_count_reg <= MSI_COUNT_RST;
            top_index_reg <= TOP_INDEX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MSI_BASE:  msi_base_reg  <= cfg_wdata[9:0];
                CFG_MSI_COUNT: msi_count_reg <= cfg_wdata;
                CFG_TOP_INDEX: top_index_reg <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    assign top_ext   = SCAN_W'(top_index_reg);
    assign lim       = (top_ext > SCAN_W'(NUM_LINES - 1)) ? SCAN_W'(NUM_LINES - 1) : top_ext;
    assign win_end   = SCAN_W'(msi_base_reg) + SCAN_W'(msi_count_reg);
    assign pos       = i_reg + SCAN_W'(j_reg);
    assign line_ext  = SCAN_W'(in_reg.line);
    assign count_ext = RUN_W'(in_reg.count);
    assign step      = in_reg.aligned ? SCAN_W'(count_ext) : SCAN_W'(j_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.scan_init) begin
            i_reg <= SCAN_W'(msi_base_reg);
        end else if (cmd.i_inc) begin
            i_reg <= i_reg + SCAN_W'(1);
        end else if (cmd.i_adv) begin
            i_reg <= i_reg + step;
        end
        if (cmd.scan_init || cmd.j_clear) begin
            j_reg <= '0;
        end else if (cmd.j_inc) begin
            j_reg <= j_reg + RUN_W'(1);
        end
        if (cmd.pend_set) begin
            case (cmd.pend_code)
                RES_OK_ZERO: begin
                    pend_ok_reg    <= 1'b1;
                    pend_first_reg <= '0;
                end
                RES_OK_RUN: begin
                    pend_ok_reg    <= 1'b1;
                    pend_first_reg <= i_reg[LINE_FW-1:0];
                end
                default: begin
                    pend_ok_reg    <= 1'b0;
                    pend_first_reg <= '0;
                end
            endcase
        end
        if (cmd.out_load) begin
            m_data_reg.ok         <= pend_ok_reg;
            m_data_reg.first_line <= pend_first_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + LINE_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        ram_we    = cmd.wr_en;
        ram_waddr = clr_reg;
        ram_wdata = 1'b0;
        case (cmd.wr_src)
            WR_CLEAR: begin
                ram_waddr = clr_reg;
                ram_wdata = 1'b0;
            end
            WR_LINE: begin
                ram_waddr = line_ext[LINE_W-1:0];
                ram_wdata = (in_reg.cmd == CMD_INSTALL);
            end
            WR_MARK: begin
                ram_waddr = pos[LINE_W-1:0];
                ram_wdata = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    ira_ram #(
        .WIDTH (1),
        .DEPTH (NUM_LINES)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (pos[LINE_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        status            = '0;
        status.clr_last   = (clr_reg == LINE_W'(NUM_LINES - 1));
        status.cmd        = in_reg.cmd;
        status.too_big    = (count_ext > RUN_W'(MAX_RUN));
        status.line_ok    = (line_ext < SCAN_W'(NUM_LINES));
        status.outer_ok   = (i_reg < win_end) && (i_reg <= lim);
        status.inner_ok   = (pos <= lim) && (j_reg < count_ext);
        status.bit_taken  = ram_rdata;
        status.count_zero = (count_ext == '0);
        status.run_done   = (j_reg == count_ext);
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* rtl/irq_range_allocator.sv */
// ----------------------------------------------------------------------------
// irq_range_allocator
// Bitmap allocator for contiguous runs of interrupt lines in a message window.
//
//   port group   dir  handshake          payload
//   s_*          in   s_valid/s_ready    in_item_t  (cmd, line, count, aligned)
//   m_*          out  m_valid/m_ready    out_item_t (ok, first_line)
//   cfg_*        in   cfg_we             cfg_index, cfg_wdata
//
// After reset a clearing pass frees every line; no item is taken during it.
// Install and uninstall write their line, if it is in range, in the dispatch
// state. A reserve reads each map line that it tests from the registered RAM
// read port and checks it in an evaluate state, and a run cut by a taken line
// or by the limit passes through a stop state before the scan moves on. A
// grant then marks its run at one line per cycle. One item is in work at a
// time; the next is taken while a result waits in the output register, and
// the sequencer holds in its last state while m_ready is low and that
// register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module irq_range_allocator
    import ira_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_wdata
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    ira_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    ira_dp #(
        .NUM_LINES (NUM_LINES),
        .MAX_RUN   (MAX_RUN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

endmodule

`default_nettype wire

/* bench/irq_range_allocator_tb.sv */
// ----------------------------------------------------------------------------
// irq_range_allocator_tb
// Self-checking bench for the interrupt line range allocator: drives reserve,
// install and uninstall items under several window and limit settings, keeps
// its own copy of the taken map to predict every result, and checks the
// results in order while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module irq_range_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ira_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int HOLD_CYCLES = 400;

    // tracks the taken map and window registers, predicts each grant
    class alloc_checker;
        bit          taken [NUM_LINES_DEF];
        int unsigned msi_base;
        int unsigned msi_count;
        int unsigned top_index;
        out_item_t   grant_q[$];
        int          mismatches;

        function new();
            foreach (taken[k]) taken[k] = 1'b0;
            msi_base   = MSI_BASE_RST;
            msi_count  = MSI_COUNT_RST;
            top_index  = TOP_INDEX_RST;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, int unsigned val);
            case (idx)
                CFG_MSI_BASE:  msi_base  = val & 'h3FF;
                CFG_MSI_COUNT: msi_count = val & 'h7FF;
                CFG_TOP_INDEX: top_index = val & 'h3FF;
                default: ;
            endcase
        endfunction

        function out_item_t predict_grant(in_item_t it);
            out_item_t res;
            int lim, stop, i, j, n, k;
            res = '0;
            n = it.count;
            case (it.cmd)
                CMD_RESERVE: begin
                    if (n <= MAX_RUN_DEF) begin
                        lim = (top_index > NUM_LINES_DEF - 1) ? NUM_LINES_DEF - 1 : top_index;
                        stop = msi_base + msi_count;
                        i = msi_base;
                        while (i < stop && i <= lim && !res.ok) begin
                            if (taken[i]) begin
                                i++;
                            end else begin
                                j = 0;
                                while (i + j <= lim && j < n && !taken[i + j]) j++;
                                if (j == n) begin
                                    for (k = 0; k < n; k++) taken[i + k] = 1'b1;
                                    res.ok = 1'b1;
                                    res.first_line = LINE_FW'(i);
                                end else begin
                                    i += it.aligned ? n : j;
                                end
                            end
                        end
                    end
                end
                CMD_INSTALL, CMD_UNINSTALL: begin
                    if (it.line < NUM_LINES_DEF) begin
                        taken[it.line] = (it.cmd == CMD_INSTALL);
                        res.ok = 1'b1;
                    end
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_item(in_item_t it);
            grant_q.push_back(predict_grant(it));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (grant_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ok=%0d first_line=%0d",
                             got.ok, got.first_line);
                return;
            end
            want = grant_q.pop_front();
            if (got.ok !== want.ok || got.first_line !== want.first_line) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected ok=%0d first_line=%0d, got ok=%0d first_line=%0d",
                             want.ok, want.first_line, got.ok, got.first_line);
            end
        endfunction

        function int pending();
            return grant_q.size();
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    alloc_checker sb;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int ready_left = 0;
    int calm_left = 0;

    irq_range_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver: random ready pattern, plus a long hold-off when requested
    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(0, 4);
            end else if (r < 65) begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(50, 200);
            end else if (r < 95) begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(0, 3);
            end else begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(10, 60);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    function int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_req(logic [1:0] cmd, int line, int count, bit aligned);
        in_item_t it;
        it.cmd     = cmd;
        it.line    = LINE_FW'(line);
        it.count   = COUNT_FW'(count);
        it.aligned = aligned;
        send_item(it);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_config(int unsigned base, int unsigned cnt, int unsigned top);
        int unsigned vals [3];
        logic [CFG_IW-1:0] idxs [3];
        vals = '{base, cnt, top};
        idxs = '{CFG_MSI_BASE, CFG_MSI_COUNT, CFG_TOP_INDEX};
        for (int k = 0; k < 3; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idxs[k];
            cfg_wdata <= CFG_DW'(vals[k]);
            @(posedge aclk);
            sb.write_reg(idxs[k], vals[k]);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly reserves and line updates near the window, some noise
    function automatic in_item_t make_item();
        in_item_t it;
        int r;
        it.aligned = 1'($urandom_range(0, 1));
        it.line    = LINE_FW'((sb.msi_base + $urandom_range(0, sb.msi_count + 32))
                              % NUM_LINES_DEF);
        it.count   = COUNT_FW'($urandom_range(1, 4));
        it.cmd     = CMD_RESERVE;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            // small run, already set
        end else if (r < 30) begin
            it.count = COUNT_FW'($urandom_range(0, MAX_RUN_DEF));
        end else if (r < 35) begin
            it.count = COUNT_FW'($urandom_range(MAX_RUN_DEF + 1, 63));
        end else if (r < 40) begin
            it.count = '0;
        end else if (r < 55) begin
            it.cmd = CMD_INSTALL;
        end else if (r < 85) begin
            it.cmd = CMD_UNINSTALL;
        end else if (r < 90) begin
            it.cmd  = $urandom_range(0, 1) ? CMD_INSTALL : CMD_UNINSTALL;
            it.line = LINE_FW'($urandom_range(0, NUM_LINES_DEF - 1));
        end else begin
            it.cmd   = CMD_UNKNOWN;
            it.line  = LINE_FW'($urandom_range(0, NUM_LINES_DEF - 1));
            it.count = COUNT_FW'($urandom_range(0, 63));
        end
        return it;
    endfunction

    task automatic run_phase(int unsigned base, int unsigned cnt, int unsigned top, int n);
        set_config(base, cnt, top);
        repeat (n) send_item(make_item());
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // wait out the map clearing pass
        while (!s_ready) @(posedge aclk);

        // default window is empty
        send_req(CMD_RESERVE, 0, 1, 1'b0);
        wait_drained();

        set_config(0, 64, 1023);
        send_req(CMD_RESERVE, 0, 0, 1'b0);
        send_req(CMD_RESERVE, 0, 1, 1'b0);
        send_req(CMD_RESERVE, 0, MAX_RUN_DEF, 1'b0);
        send_req(CMD_RESERVE, 0, MAX_RUN_DEF + 1, 1'b0);
        send_req(CMD_RESERVE, 1023, 63, 1'b1);
        send_req(CMD_UNINSTALL, 10, 0, 1'b0);
        // single-line hole blocks a run of two, plain and aligned stepping
        send_req(CMD_RESERVE, 0, 2, 1'b0);
        send_req(CMD_RESERVE, 0, 2, 1'b1);
        send_req(CMD_INSTALL, 1023, 0, 1'b0);
        send_req(CMD_UNINSTALL, 1023, 0, 1'b0);
        send_req(CMD_INSTALL, 0, 0, 1'b0);
        send_req(CMD_UNKNOWN, 1023, 63, 1'b1);
        send_req(CMD_RESERVE, 0, 0, 1'b1);
        wait_drained();

        // limit below the window end
        set_config(0, 64, 20);
        send_req(CMD_RESERVE, 0, 1, 1'b0);
        send_req(CMD_RESERVE, 0, 1, 1'b0);
        wait_drained();

        set_config(1023, 1024, 1023);
        send_req(CMD_RESERVE, 0, 2, 1'b0);
        send_req(CMD_RESERVE, 0, 1, 1'b0);
        send_req(CMD_UNINSTALL, 1023, 0, 1'b0);
        wait_drained();

        set_config(0, 0, 0);
        send_req(CMD_RESERVE, 0, 0, 1'b0);
        wait_drained();

        set_config(0, 64, 1023);
        repeat (75) send_item(make_item());
        // receiver holds off while items keep coming
        hold_req <= hold_req + 1;
        repeat (12) send_item(make_item());
        wait_drained();
        run_phase(0, 64, 1023, 70);

        run_phase(1023, 1, 1023, 40);
        run_phase(900, 200, 950, 80);
        run_phase(0, 1024, 1023, 60);
        run_phase(100, 40, 0, 30);
        repeat (4) begin
            run_phase($urandom_range(0, 1023), $urandom_range(0, 160),
                      $urandom_range(0, 1023), 80);
        end
        run_phase(500, 0, 600, 20);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
